### src/kpg_pkg.sv
package kpg_pkg;

  // Grid and store sizes
  localparam int GRID_COLS   = 64;
  localparam int GRID_ROWS   = 48;
  localparam int MAX_POINTS  = 1024;
  localparam int MAX_MATCHES = 64;
  localparam int NCELLS      = GRID_COLS * GRID_ROWS;

  localparam int COL_W   = 6;
  localparam int ROW_W   = 6;
  localparam int IDX_W   = 10;
  localparam int CNT_W   = 11;
  localparam int CELL_AW = $clog2(NCELLS);
  localparam int MATCH_W = $clog2(MAX_MATCHES + 1);
  localparam int CELL_DW = 1 + 2 * IDX_W;
  localparam int PT_DW   = 17 + 17 + 3;

  // Register map, word index
  typedef enum logic [1:0] {
    REG_ORIGIN_X = 2'd0,
    REG_ORIGIN_Y = 2'd1,
    REG_INV_W    = 2'd2,
    REG_INV_H    = 2'd3
  } reg_idx_t;

  typedef enum logic [1:0] {
    MODE_CLEAR  = 2'd0,
    MODE_INSERT = 2'd1,
    MODE_QUERY  = 2'd2,
    MODE_NOP    = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_OUTSIDE = 2'd1,
    ST_FULL    = 2'd2,
    ST_TRUNC   = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    F_IDLE,
    F_MUL,
    F_FIN
  } front_state_t;

  typedef enum logic [3:0] {
    B_SWEEP,
    B_IDLE,
    B_INS_WR,
    B_EMIT,
    B_Q_CELL,
    B_Q_CELLD,
    B_Q_PT,
    B_Q_PTD,
    B_Q_END
  } back_state_t;

  typedef struct packed {
    logic signed [16:0] origin_x;
    logic signed [16:0] origin_y;
    logic [15:0]        inv_w;
    logic [15:0]        inv_h;
  } cfg_t;

  typedef struct packed {
    mode_t              mode;
    logic signed [16:0] pos_x;
    logic signed [16:0] pos_y;
    logic [2:0]         level;
    logic [11:0]        radius;
    logic signed [3:0]  min_level;
    logic signed [3:0]  max_level;
  } item_t;

  // Classified command handed from front to back
  typedef struct packed {
    item_t            item;
    logic             in_grid;
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
    logic             win_empty;
    logic [COL_W-1:0] c0;
    logic [COL_W-1:0] c1;
    logic [ROW_W-1:0] r0;
    logic [ROW_W-1:0] r1;
  } cmd_t;

  typedef struct packed {
    logic [IDX_W-1:0] point_index;
    logic [COL_W-1:0] cell_col;
    logic [ROW_W-1:0] cell_row;
    logic             is_match;
    status_t          status;
    logic             last;
  } res_t;

  function automatic logic [CELL_AW-1:0] cell_addr(input logic [COL_W-1:0] col,
                                                   input logic [ROW_W-1:0] row);
    return CELL_AW'(int'(col) * GRID_ROWS + int'(row));
  endfunction

endpackage

### src/kpg_front.sv
module kpg_front (
  input  logic           clk,
  input  logic           rst,
  input  kpg_pkg::cfg_t  cfg,
  input  logic           in_valid,
  output logic           in_ready,
  input  kpg_pkg::item_t in_item,
  output logic           push,
  input  logic           q_full,
  output kpg_pkg::cmd_t  push_cmd
);

  kpg_pkg::front_state_t state, state_next;
  kpg_pkg::item_t        item;
  logic [1:0]            step;
  logic signed [35:0]    prod [4];

  logic signed [17:0] ox, oy;
  logic signed [18:0] re, a, a_sum;
  logic signed [16:0] b;
  logic signed [35:0] prod_c;

  logic signed [16:0] col_r, row_r, c0f, c1f, r0f, r1f, c0c, c1c, r0c, r1c;

  localparam logic signed [16:0] COLS_M1 = 17'(kpg_pkg::GRID_COLS - 1);
  localparam logic signed [16:0] ROWS_M1 = 17'(kpg_pkg::GRID_ROWS - 1);

  function automatic logic signed [16:0] floor20(input logic signed [35:0] p);
    logic signed [35:0] s;
    s = p >>> 20;
    return s[16:0];
  endfunction

  function automatic logic signed [16:0] ceil20(input logic signed [35:0] p);
    logic signed [36:0] s;
    s = ($signed({p[35], p}) + 37'sd1048575) >>> 20;
    return s[16:0];
  endfunction

  // Round half away from zero
  function automatic logic signed [16:0] round20(input logic signed [35:0] p);
    logic [35:0] m;
    logic [35:0] q;
    m = p[35] ? 36'(-p) : 36'(p);
    q = (m + 36'd524288) >> 20;
    return p[35] ? -$signed(q[16:0]) : $signed(q[16:0]);
  endfunction

  // Shared multiplier operands, one product per step
  always_comb begin
    ox = $signed({item.pos_x[16], item.pos_x}) - $signed({cfg.origin_x[16], cfg.origin_x});
    oy = $signed({item.pos_y[16], item.pos_y}) - $signed({cfg.origin_y[16], cfg.origin_y});
    re = (item.mode == kpg_pkg::MODE_QUERY) ? $signed({7'b0, item.radius}) : 19'sd0;
    a = step[1] ? $signed({oy[17], oy}) : $signed({ox[17], ox});
    a_sum = step[0] ? a + re : a - re;
    b = $signed({1'b0, step[1] ? cfg.inv_h : cfg.inv_w});
    prod_c = a_sum * b;
  end

  // Cell, window and clamping from the stored products
  always_comb begin
    col_r = round20(prod[0]);
    row_r = round20(prod[2]);
    c0f = floor20(prod[0]);
    c1f = ceil20(prod[1]);
    r0f = floor20(prod[2]);
    r1f = ceil20(prod[3]);
    c0c = (c0f < 0) ? 17'sd0 : c0f;
    c1c = (c1f > COLS_M1) ? COLS_M1 : c1f;
    r0c = (r0f < 0) ? 17'sd0 : r0f;
    r1c = (r1f > ROWS_M1) ? ROWS_M1 : r1f;

    push_cmd.item      = item;
    push_cmd.in_grid   = (col_r >= 0) && (col_r <= COLS_M1) && (row_r >= 0) && (row_r <= ROWS_M1);
    push_cmd.col       = col_r[kpg_pkg::COL_W-1:0];
    push_cmd.row       = row_r[kpg_pkg::ROW_W-1:0];
    push_cmd.win_empty = (c0c > c1c) || (r0c > r1c);
    push_cmd.c0        = c0c[kpg_pkg::COL_W-1:0];
    push_cmd.c1        = c1c[kpg_pkg::COL_W-1:0];
    push_cmd.r0        = r0c[kpg_pkg::ROW_W-1:0];
    push_cmd.r1        = r1c[kpg_pkg::ROW_W-1:0];
  end

  // Next state and handshake
  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    push       = 1'b0;
    case (state)
      kpg_pkg::F_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_item.mode == kpg_pkg::MODE_INSERT || in_item.mode == kpg_pkg::MODE_QUERY)
            state_next = kpg_pkg::F_MUL;
          else
            state_next = kpg_pkg::F_FIN;
        end
      end
      kpg_pkg::F_MUL: begin
        if (step == 2'd3) state_next = kpg_pkg::F_FIN;
      end
      kpg_pkg::F_FIN: begin
        if (!q_full) begin
          push       = 1'b1;
          state_next = kpg_pkg::F_IDLE;
        end
      end
      default: state_next = kpg_pkg::F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= kpg_pkg::F_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Capture item and products
  always_ff @(posedge clk) begin
    if (state == kpg_pkg::F_IDLE && in_valid) begin
      item <= in_item;
      step <= 2'd0;
    end
    if (state == kpg_pkg::F_MUL) begin
      prod[step] <= prod_c;
      step       <= step + 2'd1;
    end
  end

endmodule

### src/kpg_queue.sv
module kpg_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  kpg_pkg::cmd_t push_cmd,
  output logic          full,
  input  logic          pop,
  output logic          valid,
  output kpg_pkg::cmd_t pop_cmd
);

  kpg_pkg::cmd_t mem [2];
  logic          wr_ptr, rd_ptr;
  logic [1:0]    cnt;

  assign full    = (cnt == 2'd2);
  assign valid   = (cnt != 2'd0);
  assign pop_cmd = mem[rd_ptr];

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      cnt    <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      if (push && !pop) cnt <= cnt + 2'd1;
      else if (pop && !push) cnt <= cnt - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_cmd;
  end

endmodule

### src/kpg_back.sv
module kpg_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          q_valid,
  input  kpg_pkg::cmd_t q_cmd,
  output logic          pop,
  output logic          out_valid,
  input  logic          out_ready,
  output kpg_pkg::res_t out_data
);

  localparam int IW = kpg_pkg::IDX_W;
  localparam int AW = kpg_pkg::CELL_AW;

  // Memories
  logic [kpg_pkg::CELL_DW-1:0] cell_mem [kpg_pkg::NCELLS];
  logic [kpg_pkg::PT_DW-1:0]   pt_mem   [kpg_pkg::MAX_POINTS];
  logic [IW-1:0]               nx_mem   [kpg_pkg::MAX_POINTS];

  logic                        cell_we, cell_re, pt_we, pt_re, nx_we;
  logic [AW-1:0]               cell_wa, cell_ra;
  logic [kpg_pkg::CELL_DW-1:0] cell_wd, cell_rd;
  logic [IW-1:0]               pt_wa, pt_ra, nx_wa, nx_wd, nx_rd;
  logic [kpg_pkg::PT_DW-1:0]   pt_wd, pt_rd;

  // Control registers
  kpg_pkg::back_state_t state, state_next;
  kpg_pkg::cmd_t        cmd, cmd_next;
  logic [kpg_pkg::CNT_W-1:0]   count, count_next;
  logic [AW-1:0]               sweep_addr, sweep_addr_next;
  logic                        sweep_emit, sweep_emit_next;
  logic [kpg_pkg::COL_W-1:0]   ix, ix_next;
  logic [kpg_pkg::ROW_W-1:0]   iy, iy_next;
  logic [IW-1:0]               cur_p, cur_p_next, cur_tail, cur_tail_next;
  logic [kpg_pkg::MATCH_W-1:0] n, n_next;
  kpg_pkg::res_t               held, held_next, pend, pend_next, out_next;
  logic                        held_valid, held_valid_next, trunc, trunc_next;
  logic                        out_load, out_free;

  // Walk helpers
  logic                        cell_used;
  logic [IW-1:0]               cell_head, cell_tail;
  logic                        adv_done;
  logic [kpg_pkg::COL_W-1:0]   adv_ix;
  logic [kpg_pkg::ROW_W-1:0]   adv_iy;
  logic signed [16:0]          px, py;
  logic [2:0]                  plvl;
  logic signed [17:0]          dx, dy;
  logic [17:0]                 adx, ady;
  logic                        lvl_ok, hit;
  kpg_pkg::res_t               zero_res;

  assign out_free = !out_valid || out_ready;
  assign {cell_used, cell_head, cell_tail} = cell_rd;
  assign {plvl, py, px} = pt_rd;

  always_comb begin
    zero_res = '0;
    zero_res.status = kpg_pkg::ST_OK;
    zero_res.last   = 1'b1;
  end

  // Next cell in column-major order
  always_comb begin
    adv_done = 1'b0;
    adv_ix   = ix;
    adv_iy   = iy;
    if (iy != cmd.r1) begin
      adv_iy = iy + 1'b1;
    end else if (ix != cmd.c1) begin
      adv_ix = ix + 1'b1;
      adv_iy = cmd.r0;
    end else begin
      adv_done = 1'b1;
    end
  end

  // Window and level test on the fetched point
  always_comb begin
    dx  = $signed({px[16], px}) - $signed({cmd.item.pos_x[16], cmd.item.pos_x});
    dy  = $signed({py[16], py}) - $signed({cmd.item.pos_y[16], cmd.item.pos_y});
    adx = dx[17] ? 18'(-dx) : 18'(dx);
    ady = dy[17] ? 18'(-dy) : 18'(dy);
    lvl_ok = 1'b1;
    if (cmd.item.min_level > 4'sd0 || cmd.item.max_level >= 4'sd0) begin
      if ($signed({2'b00, plvl}) < $signed({cmd.item.min_level[3], cmd.item.min_level}))
        lvl_ok = 1'b0;
      if (cmd.item.max_level >= 4'sd0 &&
          $signed({2'b00, plvl}) > $signed({cmd.item.max_level[3], cmd.item.max_level}))
        lvl_ok = 1'b0;
    end
    hit = lvl_ok && (adx < {6'b0, cmd.item.radius}) && (ady < {6'b0, cmd.item.radius});
  end

  // Next state and memory controls
  always_comb begin
    state_next      = state;
    cmd_next        = cmd;
    count_next      = count;
    sweep_addr_next = sweep_addr;
    sweep_emit_next = sweep_emit;
    ix_next         = ix;
    iy_next         = iy;
    cur_p_next      = cur_p;
    cur_tail_next   = cur_tail;
    n_next          = n;
    held_next       = held;
    held_valid_next = held_valid;
    trunc_next      = trunc;
    pend_next       = pend;
    out_load        = 1'b0;
    out_next        = zero_res;
    pop             = 1'b0;
    cell_we = 1'b0; cell_wa = sweep_addr; cell_wd = '0;
    cell_re = 1'b0; cell_ra = kpg_pkg::cell_addr(ix, iy);
    pt_we = 1'b0; pt_wa = count[IW-1:0];
    pt_wd = {q_cmd.item.level, q_cmd.item.pos_y, q_cmd.item.pos_x};
    pt_re = 1'b0; pt_ra = cur_p;
    nx_we = 1'b0; nx_wa = cell_tail; nx_wd = count[IW-1:0];

    case (state)
      kpg_pkg::B_SWEEP: begin
        cell_we         = 1'b1;
        sweep_addr_next = sweep_addr + 1'b1;
        if (sweep_addr == AW'(kpg_pkg::NCELLS - 1)) begin
          pend_next  = zero_res;
          state_next = sweep_emit ? kpg_pkg::B_EMIT : kpg_pkg::B_IDLE;
        end
      end
      kpg_pkg::B_IDLE: begin
        if (q_valid) begin
          pop      = 1'b1;
          cmd_next = q_cmd;
          case (q_cmd.item.mode)
            kpg_pkg::MODE_CLEAR: begin
              count_next      = '0;
              sweep_addr_next = '0;
              sweep_emit_next = 1'b1;
              state_next      = kpg_pkg::B_SWEEP;
            end
            kpg_pkg::MODE_INSERT: begin
              pend_next = zero_res;
              if (count >= kpg_pkg::CNT_W'(kpg_pkg::MAX_POINTS)) begin
                pend_next.status = kpg_pkg::ST_FULL;
                state_next       = kpg_pkg::B_EMIT;
              end else begin
                pt_we = 1'b1;
                pend_next.point_index = count[IW-1:0];
                if (!q_cmd.in_grid) begin
                  pend_next.status = kpg_pkg::ST_OUTSIDE;
                  count_next       = count + 1'b1;
                  state_next       = kpg_pkg::B_EMIT;
                end else begin
                  cell_re    = 1'b1;
                  cell_ra    = kpg_pkg::cell_addr(q_cmd.col, q_cmd.row);
                  state_next = kpg_pkg::B_INS_WR;
                end
              end
            end
            kpg_pkg::MODE_QUERY: begin
              n_next          = '0;
              held_valid_next = 1'b0;
              trunc_next      = 1'b0;
              ix_next         = q_cmd.c0;
              iy_next         = q_cmd.r0;
              state_next      = q_cmd.win_empty ? kpg_pkg::B_Q_END : kpg_pkg::B_Q_CELL;
            end
            default: begin
              pend_next  = zero_res;
              state_next = kpg_pkg::B_EMIT;
            end
          endcase
        end
      end
      kpg_pkg::B_INS_WR: begin
        // Append to the cell list
        nx_we   = cell_used;
        cell_we = 1'b1;
        cell_wa = kpg_pkg::cell_addr(cmd.col, cmd.row);
        cell_wd = {1'b1, cell_used ? cell_head : count[IW-1:0], count[IW-1:0]};
        pend_next.cell_col = cmd.col;
        pend_next.cell_row = cmd.row;
        count_next = count + 1'b1;
        state_next = kpg_pkg::B_EMIT;
      end
      kpg_pkg::B_EMIT: begin
        if (out_free) begin
          out_load   = 1'b1;
          out_next   = pend;
          state_next = kpg_pkg::B_IDLE;
        end
      end
      kpg_pkg::B_Q_CELL: begin
        cell_re    = 1'b1;
        state_next = kpg_pkg::B_Q_CELLD;
      end
      kpg_pkg::B_Q_CELLD: begin
        if (cell_used) begin
          cur_p_next    = cell_head;
          cur_tail_next = cell_tail;
          state_next    = kpg_pkg::B_Q_PT;
        end else begin
          ix_next    = adv_ix;
          iy_next    = adv_iy;
          state_next = adv_done ? kpg_pkg::B_Q_END : kpg_pkg::B_Q_CELL;
        end
      end
      kpg_pkg::B_Q_PT: begin
        pt_re      = 1'b1;
        state_next = kpg_pkg::B_Q_PTD;
      end
      kpg_pkg::B_Q_PTD: begin
        if (hit && n == kpg_pkg::MATCH_W'(kpg_pkg::MAX_MATCHES)) begin
          trunc_next = 1'b1;
          state_next = kpg_pkg::B_Q_END;
        end else if (!(hit && held_valid && !out_free)) begin
          if (hit) begin
            // Release the previous match, hold this one
            out_load = held_valid;
            out_next = held;
            held_next.point_index = cur_p;
            held_next.cell_col    = ix;
            held_next.cell_row    = iy;
            held_next.is_match    = 1'b1;
            held_next.status      = kpg_pkg::ST_OK;
            held_next.last        = 1'b0;
            held_valid_next       = 1'b1;
            n_next                = n + 1'b1;
          end
          if (cur_p == cur_tail) begin
            ix_next    = adv_ix;
            iy_next    = adv_iy;
            state_next = adv_done ? kpg_pkg::B_Q_END : kpg_pkg::B_Q_CELL;
          end else begin
            cur_p_next = nx_rd;
            state_next = kpg_pkg::B_Q_PT;
          end
        end
      end
      kpg_pkg::B_Q_END: begin
        if (out_free) begin
          out_load = 1'b1;
          if (held_valid) begin
            out_next      = held;
            out_next.last = 1'b1;
            if (trunc) out_next.status = kpg_pkg::ST_TRUNC;
          end
          held_valid_next = 1'b0;
          state_next      = kpg_pkg::B_IDLE;
        end
      end
      default: state_next = kpg_pkg::B_IDLE;
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= kpg_pkg::B_SWEEP;
      count      <= '0;
      sweep_addr <= '0;
      sweep_emit <= 1'b0;
      held_valid <= 1'b0;
      trunc      <= 1'b0;
      n          <= '0;
      out_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      count      <= count_next;
      sweep_addr <= sweep_addr_next;
      sweep_emit <= sweep_emit_next;
      held_valid <= held_valid_next;
      trunc      <= trunc_next;
      n          <= n_next;
      if (out_load) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    cmd      <= cmd_next;
    ix       <= ix_next;
    iy       <= iy_next;
    cur_p    <= cur_p_next;
    cur_tail <= cur_tail_next;
    held     <= held_next;
    pend     <= pend_next;
    if (out_load) out_data <= out_next;
  end

  // Cell table
  always_ff @(posedge clk) begin
    if (cell_we) cell_mem[cell_wa] <= cell_wd;
    if (cell_re) cell_rd <= cell_mem[cell_ra];
  end

  // Point store and links
  always_ff @(posedge clk) begin
    if (pt_we) pt_mem[pt_wa] <= pt_wd;
    if (pt_re) pt_rd <= pt_mem[pt_ra];
  end

  always_ff @(posedge clk) begin
    if (nx_we) nx_mem[nx_wa] <= nx_wd;
    if (pt_re) nx_rd <= nx_mem[pt_ra];
  end

endmodule

### src/keypoint_grid_bin_and_area_query.sv
// Keypoint grid: stores keypoints, bins them into a 64 x 48 cell grid and
// answers square-window queries over the cells.
// Input stream (s_*): one transaction per command; tuser carries the mode
// (clear, insert, query, no-op), tdata the position, level and query window.
// Output stream (m_*): one or more result transactions per command; tlast
// marks the final one. Inserts and clears give exactly one result.
// Configuration (APB): origin and cell inverses at word addresses 0..3;
// write only while no command is in flight.
// Front end: each insert or query takes 4 shared-multiplier steps, while a
// clear or no-op skips them; a two-entry queue then feeds the back end.
// A query walks each visited cell and each listed point, so query time
// follows grid occupancy. A clear sweeps all 3072 cells of the cell table
// at one cell per cycle. Reset runs the same sweep; commands are queued
// but not executed until it completes, configuration writes are taken at once.
// When m_tready is low the output register holds its result; the back end
// keeps working until it has another result to deliver, and the queue
// lets the front end accept up to three further commands meanwhile.
module keypoint_grid_bin_and_area_query (
  input  logic        clk,
  input  logic        rst,
  // APB configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // Command stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,  // pos_x, pos_y, level, radius, min_level, max_level
  input  logic [1:0]  s_tuser,  // mode
  // Result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,  // point_index, cell_col, cell_row
  output logic [2:0]  m_tuser,  // is_match, status
  output logic        m_tlast
);

  kpg_pkg::cfg_t  cfg;
  kpg_pkg::item_t in_item;
  kpg_pkg::cmd_t  push_cmd, pop_cmd;
  kpg_pkg::res_t  res;
  logic           push, q_full, pop, q_valid;
  logic           cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.origin_x <= '0;
      cfg.origin_y <= '0;
      cfg.inv_w    <= 16'd6554;
      cfg.inv_h    <= 16'd6554;
    end else if (cfg_wr) begin
      case (kpg_pkg::reg_idx_t'(paddr[3:2]))
        kpg_pkg::REG_ORIGIN_X: cfg.origin_x <= pwdata[16:0];
        kpg_pkg::REG_ORIGIN_Y: cfg.origin_y <= pwdata[16:0];
        kpg_pkg::REG_INV_W:    cfg.inv_w    <= pwdata[15:0];
        kpg_pkg::REG_INV_H:    cfg.inv_h    <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (kpg_pkg::reg_idx_t'(paddr[3:2]))
      kpg_pkg::REG_ORIGIN_X: prdata = {{15{cfg.origin_x[16]}}, cfg.origin_x};
      kpg_pkg::REG_ORIGIN_Y: prdata = {{15{cfg.origin_y[16]}}, cfg.origin_y};
      kpg_pkg::REG_INV_W:    prdata = {16'b0, cfg.inv_w};
      kpg_pkg::REG_INV_H:    prdata = {16'b0, cfg.inv_h};
      default:               prdata = '0;
    endcase
  end

  // Unpack the command transaction
  always_comb begin
    in_item.mode      = kpg_pkg::mode_t'(s_tuser);
    in_item.pos_x     = s_tdata[16:0];
    in_item.pos_y     = s_tdata[33:17];
    in_item.level     = s_tdata[36:34];
    in_item.radius    = s_tdata[48:37];
    in_item.min_level = s_tdata[52:49];
    in_item.max_level = s_tdata[56:53];
  end

  kpg_front u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .in_item  (in_item),
    .push     (push),
    .q_full   (q_full),
    .push_cmd (push_cmd)
  );

  kpg_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (pop),
    .valid    (q_valid),
    .pop_cmd  (pop_cmd)
  );

  kpg_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_cmd     (pop_cmd),
    .pop       (pop),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (res)
  );

  // Pack the result transaction
  assign m_tdata = {2'b00, res.cell_row, res.cell_col, res.point_index};
  assign m_tuser = {res.status, res.is_match};
  assign m_tlast = res.last;

endmodule
